FILE: rtl/core/xnbhp_pkg.sv
`timescale 1ns / 1ps
// xnbhp_pkg: shared types and constants for the content-file header parser
// depends on nothing; used by every file under rtl/core

package xnbhp_pkg;

    // parse phases, one per header field position
    typedef enum logic [3:0] {
        PH_MAGIC0   = 4'd0,
        PH_MAGIC1   = 4'd1,
        PH_MAGIC2   = 4'd2,
        PH_TARGET   = 4'd3,
        PH_VERSION  = 4'd4,
        PH_FLAGS    = 4'd5,
        PH_CSIZE    = 4'd6,
        PH_USIZE    = 4'd7,
        PH_RCOUNT   = 4'd8,
        PH_NAMELEN  = 4'd9,
        PH_NAMESKIP = 4'd10,
        PH_RVERSION = 4'd11,
        PH_SHARED   = 4'd12,
        PH_DONE     = 4'd13
    } phase_t;

    // result status codes
    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_MAGIC    = 3'd1,
        ST_TARGET   = 3'd2,
        ST_VERSION  = 3'd3,
        ST_TRUNC    = 3'd4,
        ST_OVERLONG = 3'd5,
        ST_NEGATIVE = 3'd6
    } status_t;

    // input transaction kinds
    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_END     = 2'd1,
        KIND_RESTART = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    // target platform codes
    localparam logic [1:0] TGT_WINDOWS = 2'd0;
    localparam logic [1:0] TGT_PHONE   = 2'd1;
    localparam logic [1:0] TGT_CONSOLE = 2'd2;

    // header byte constants
    localparam logic [7:0] CH_X        = 8'h58;
    localparam logic [7:0] CH_N        = 8'h4e;
    localparam logic [7:0] CH_B        = 8'h42;
    localparam logic [7:0] CH_W_LOWER  = 8'h77;
    localparam logic [7:0] CH_M_LOWER  = 8'h6d;
    localparam logic [7:0] CH_X_LOWER  = 8'h78;
    localparam logic [7:0] FMT_VERSION = 8'd5;

    // last varint byte position (fifth byte)
    localparam logic [2:0] VARINT_LAST = 3'd4;
    // last word byte position (fourth byte)
    localparam logic [1:0] WORD_LAST   = 2'd3;

    // stream widths
    localparam int TDATA_IN_W  = 8;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 136;
    localparam int TUSER_OUT_W = 3;
    localparam int PAYLOAD_W   = 130;

    // one parse result
    typedef struct packed {
        status_t     status;
        logic [1:0]  target;
        logic        high_def;
        logic        compressed;
        logic [31:0] csize;
        logic [31:0] usize;
        logic [30:0] reader_count;
        logic [30:0] shared_count;
    } result_t;

endpackage

FILE: rtl/core/xnbhp_parse_core.sv
`timescale 1ns / 1ps
// xnbhp_parse_core: header parse state and the per-byte update logic
// depends on xnbhp_pkg

module xnbhp_parse_core (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step_valid,
    input  xnbhp_pkg::kind_t     step_kind,
    input  logic [7:0]           step_byte,
    output logic                 result_valid,
    output xnbhp_pkg::result_t   result
);

    xnbhp_pkg::phase_t phase_reg, phase_next;
    logic [2:0]  bif_reg, bif_next;
    logic [31:0] varint_reg, varint_next;
    logic [31:0] word_reg, word_next;
    logic [30:0] readers_reg, readers_next;
    logic [30:0] skip_reg, skip_next;
    logic [1:0]  target_reg, target_next;
    logic [1:0]  flags_reg, flags_next;
    logic [31:0] csize_reg, csize_next;
    logic [31:0] usize_reg, usize_next;
    logic [30:0] rcount_reg, rcount_next;

    logic                 emit;
    xnbhp_pkg::status_t   emit_status;
    logic [30:0]          emit_shared;
    logic [31:0]          vsum;
    logic [31:0]          wsum;
    logic [31:0]          byte_ext;

    assign byte_ext = {24'd0, step_byte};

    // varint accumulate: seven bits per byte, upper bits of the fifth dropped
    always_comb begin
        case (bif_reg)
            3'd0:    vsum = varint_reg | {25'd0, step_byte[6:0]};
            3'd1:    vsum = varint_reg | {18'd0, step_byte[6:0], 7'd0};
            3'd2:    vsum = varint_reg | {11'd0, step_byte[6:0], 14'd0};
            3'd3:    vsum = varint_reg | {4'd0, step_byte[6:0], 21'd0};
            3'd4:    vsum = varint_reg | {step_byte[3:0], 28'd0};
            default: vsum = varint_reg;
        endcase
    end

    // little-endian word accumulate
    always_comb begin
        wsum = word_reg | (byte_ext << {bif_reg[1:0], 3'b000});
    end

    // next state
    always_comb begin
        phase_next   = phase_reg;
        bif_next     = bif_reg;
        varint_next  = varint_reg;
        word_next    = word_reg;
        readers_next = readers_reg;
        skip_next    = skip_reg;
        target_next  = target_reg;
        flags_next   = flags_reg;
        csize_next   = csize_reg;
        usize_next   = usize_reg;
        rcount_next  = rcount_reg;
        emit         = 1'b0;
        emit_status  = xnbhp_pkg::ST_OK;
        emit_shared  = 31'd0;

        if (step_valid) begin
            case (step_kind)
                xnbhp_pkg::KIND_RESTART: begin
                    phase_next   = xnbhp_pkg::PH_MAGIC0;
                    bif_next     = 3'd0;
                    varint_next  = 32'd0;
                    word_next    = 32'd0;
                    readers_next = 31'd0;
                    skip_next    = 31'd0;
                    target_next  = 2'd0;
                    flags_next   = 2'd0;
                    csize_next   = 32'd0;
                    usize_next   = 32'd0;
                    rcount_next  = 31'd0;
                end
                xnbhp_pkg::KIND_END: begin
                    if (phase_reg != xnbhp_pkg::PH_DONE) begin
                        emit        = 1'b1;
                        emit_status = xnbhp_pkg::ST_TRUNC;
                    end
                end
                xnbhp_pkg::KIND_DATA: begin
                    case (phase_reg)
                        xnbhp_pkg::PH_MAGIC0: begin
                            if (step_byte != xnbhp_pkg::CH_X) begin
                                emit        = 1'b1;
                                emit_status = xnbhp_pkg::ST_MAGIC;
                            end else begin
                                phase_next = xnbhp_pkg::PH_MAGIC1;
                            end
                        end
                        xnbhp_pkg::PH_MAGIC1: begin
                            if (step_byte != xnbhp_pkg::CH_N) begin
                                emit        = 1'b1;
                                emit_status = xnbhp_pkg::ST_MAGIC;
                            end else begin
                                phase_next = xnbhp_pkg::PH_MAGIC2;
                            end
                        end
                        xnbhp_pkg::PH_MAGIC2: begin
                            if (step_byte != xnbhp_pkg::CH_B) begin
                                emit        = 1'b1;
                                emit_status = xnbhp_pkg::ST_MAGIC;
                            end else begin
                                phase_next = xnbhp_pkg::PH_TARGET;
                            end
                        end
                        xnbhp_pkg::PH_TARGET: begin
                            phase_next = xnbhp_pkg::PH_VERSION;
                            if (step_byte == xnbhp_pkg::CH_W_LOWER) begin
                                target_next = xnbhp_pkg::TGT_WINDOWS;
                            end else if (step_byte == xnbhp_pkg::CH_M_LOWER) begin
                                target_next = xnbhp_pkg::TGT_PHONE;
                            end else if (step_byte == xnbhp_pkg::CH_X_LOWER) begin
                                target_next = xnbhp_pkg::TGT_CONSOLE;
                            end else begin
                                phase_next  = phase_reg;
                                emit        = 1'b1;
                                emit_status = xnbhp_pkg::ST_TARGET;
                            end
                        end
                        xnbhp_pkg::PH_VERSION: begin
                            if (step_byte != xnbhp_pkg::FMT_VERSION) begin
                                emit        = 1'b1;
                                emit_status = xnbhp_pkg::ST_VERSION;
                            end else begin
                                phase_next = xnbhp_pkg::PH_FLAGS;
                            end
                        end
                        xnbhp_pkg::PH_FLAGS: begin
                            flags_next = {step_byte[7], step_byte[0]};
                            bif_next   = 3'd0;
                            word_next  = 32'd0;
                            phase_next = xnbhp_pkg::PH_CSIZE;
                        end
                        xnbhp_pkg::PH_CSIZE, xnbhp_pkg::PH_USIZE,
                        xnbhp_pkg::PH_RVERSION: begin
                            if (bif_reg[1:0] != xnbhp_pkg::WORD_LAST) begin
                                word_next = wsum;
                                bif_next  = {1'b0, bif_reg[1:0] + 2'd1};
                            end else begin
                                word_next = 32'd0;
                                bif_next  = 3'd0;
                                if (phase_reg == xnbhp_pkg::PH_CSIZE) begin
                                    csize_next = wsum;
                                    if (flags_reg[1]) begin
                                        phase_next = xnbhp_pkg::PH_USIZE;
                                    end else begin
                                        usize_next = wsum;
                                        phase_next = xnbhp_pkg::PH_RCOUNT;
                                    end
                                end else if (phase_reg == xnbhp_pkg::PH_USIZE) begin
                                    usize_next = wsum;
                                    phase_next = xnbhp_pkg::PH_RCOUNT;
                                end else begin
                                    readers_next = readers_reg - 31'd1;
                                    phase_next   = (readers_reg == 31'd1) ?
                                                   xnbhp_pkg::PH_SHARED :
                                                   xnbhp_pkg::PH_NAMELEN;
                                end
                            end
                        end
                        xnbhp_pkg::PH_RCOUNT, xnbhp_pkg::PH_NAMELEN,
                        xnbhp_pkg::PH_SHARED: begin
                            if (step_byte[7]) begin
                                if (bif_reg >= xnbhp_pkg::VARINT_LAST) begin
                                    emit        = 1'b1;
                                    emit_status = xnbhp_pkg::ST_OVERLONG;
                                end else begin
                                    varint_next = vsum;
                                    bif_next    = bif_reg + 3'd1;
                                end
                            end else begin
                                varint_next = 32'd0;
                                bif_next    = 3'd0;
                                if (vsum[31]) begin
                                    emit        = 1'b1;
                                    emit_status = xnbhp_pkg::ST_NEGATIVE;
                                end else if (phase_reg == xnbhp_pkg::PH_SHARED) begin
                                    emit        = 1'b1;
                                    emit_status = xnbhp_pkg::ST_OK;
                                    emit_shared = vsum[30:0];
                                end else if (phase_reg == xnbhp_pkg::PH_RCOUNT) begin
                                    rcount_next  = vsum[30:0];
                                    readers_next = vsum[30:0];
                                    phase_next   = (vsum[30:0] == 31'd0) ?
                                                   xnbhp_pkg::PH_SHARED :
                                                   xnbhp_pkg::PH_NAMELEN;
                                end else begin
                                    skip_next  = vsum[30:0];
                                    phase_next = (vsum[30:0] == 31'd0) ?
                                                 xnbhp_pkg::PH_RVERSION :
                                                 xnbhp_pkg::PH_NAMESKIP;
                                end
                            end
                        end
                        xnbhp_pkg::PH_NAMESKIP: begin
                            skip_next = skip_reg - 31'd1;
                            if (skip_reg == 31'd1) begin
                                phase_next = xnbhp_pkg::PH_RVERSION;
                            end
                        end
                        xnbhp_pkg::PH_DONE: begin
                            phase_next = xnbhp_pkg::PH_DONE;
                        end
                        default: begin
                            phase_next = xnbhp_pkg::PH_DONE;
                        end
                    endcase
                end
                default: begin
                    phase_next = phase_reg;
                end
            endcase

            // any result closes the header
            if (emit) begin
                phase_next = xnbhp_pkg::PH_DONE;
            end
        end
    end

    // result fields
    always_comb begin
        result_valid        = emit;
        result.status       = emit_status;
        result.target       = target_reg;
        result.high_def     = flags_reg[0];
        result.compressed   = flags_reg[1];
        result.csize        = csize_reg;
        result.usize        = usize_reg;
        result.reader_count = rcount_reg;
        result.shared_count = emit_shared;
    end

    // parse state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= xnbhp_pkg::PH_MAGIC0;
            bif_reg     <= 3'd0;
            varint_reg  <= 32'd0;
            word_reg    <= 32'd0;
            readers_reg <= 31'd0;
            skip_reg    <= 31'd0;
            target_reg  <= 2'd0;
            flags_reg   <= 2'd0;
            csize_reg   <= 32'd0;
            usize_reg   <= 32'd0;
            rcount_reg  <= 31'd0;
        end else begin
            phase_reg   <= phase_next;
            bif_reg     <= bif_next;
            varint_reg  <= varint_next;
            word_reg    <= word_next;
            readers_reg <= readers_next;
            skip_reg    <= skip_next;
            target_reg  <= target_next;
            flags_reg   <= flags_next;
            csize_reg   <= csize_next;
            usize_reg   <= usize_next;
            rcount_reg  <= rcount_next;
        end
    end

endmodule

FILE: rtl/core/xnb_header_parser.sv
`timescale 1ns / 1ps
// xnb_header_parser: top level, input register, parse core and result register
// depends on xnbhp_pkg and xnbhp_parse_core
//
// Usage:
//   Slave channel s_*: one transaction per stream byte. s_tdata[7:0] holds the
//   byte, s_tuser[1:0] the kind (data byte, end of stream, restart, or an
//   unused code that is ignored). A restart clears the parser for a new file.
//   Master channel m_*: at most one transaction per file carrying the status
//   in m_tuser and the parsed header fields in m_tdata. After that result the
//   parser ignores bytes until a restart.
//   Path: the transaction that causes a result passes the input register and
//   then the result register before the result shows on m_tvalid.
//   Throughput: one transaction per cycle while no result is stalled, set by
//   the combinational update of the parse state between the two registers.
//   Reset (aresetn low, synchronous) empties both registers and returns the
//   parser to the first magic byte.
//   When the receiver stalls with a result pending, the result holds and the
//   parser does not step; the input register keeps its transaction, and once
//   it is full s_tready stays low until m_tready returns.

module xnb_header_parser (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] byte_value
    input  logic [xnbhp_pkg::TDATA_IN_W-1:0]    s_tdata,
    // [1:0] kind
    input  logic [xnbhp_pkg::TUSER_IN_W-1:0]    s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [1:0] target_platform, [2] high_def, [3] is_compressed,
    // [35:4] compressed_size, [67:36] uncompressed_size,
    // [98:68] reader_count, [129:99] shared_count, [135:130] zero
    output logic [xnbhp_pkg::TDATA_OUT_W-1:0]   m_tdata,
    // [2:0] status
    output logic [xnbhp_pkg::TUSER_OUT_W-1:0]   m_tuser
);

    logic                 in_valid_reg, in_valid_next;
    xnbhp_pkg::kind_t     in_kind_reg, in_kind_next;
    logic [7:0]           in_byte_reg, in_byte_next;
    logic                 out_valid_reg, out_valid_next;
    xnbhp_pkg::result_t   out_data_reg, out_data_next;

    logic                 advance;
    logic                 step_valid;
    logic                 core_valid;
    xnbhp_pkg::result_t   core_result;

    // the parser steps whenever a result could be stored
    assign advance    = !out_valid_reg || m_tready;
    assign step_valid = in_valid_reg && advance;
    assign s_tready   = !in_valid_reg || advance;

    xnbhp_parse_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step_valid   (step_valid),
        .step_kind    (in_kind_reg),
        .step_byte    (in_byte_reg),
        .result_valid (core_valid),
        .result       (core_result)
    );

    // input register
    always_comb begin
        in_valid_next = in_valid_reg;
        in_kind_next  = in_kind_reg;
        in_byte_next  = in_byte_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        if (s_tvalid && s_tready) begin
            in_kind_next = xnbhp_pkg::kind_t'(s_tuser[1:0]);
            in_byte_next = s_tdata[7:0];
        end
    end

    // result register
    always_comb begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (advance) begin
            out_valid_next = step_valid && core_valid;
        end
        if (step_valid && core_valid) begin
            out_data_next = core_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_kind_reg  <= in_kind_next;
        in_byte_reg  <= in_byte_next;
        out_data_reg <= out_data_next;
    end

    // master channel packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_data_reg.status;
    assign m_tdata  = {{(xnbhp_pkg::TDATA_OUT_W - xnbhp_pkg::PAYLOAD_W){1'b0}},
                       out_data_reg.shared_count,
                       out_data_reg.reader_count,
                       out_data_reg.usize,
                       out_data_reg.csize,
                       out_data_reg.compressed,
                       out_data_reg.high_def,
                       out_data_reg.target};

endmodule

FILE: rtl/core/xnbhp_checker.sv
`timescale 1ns / 1ps
// xnbhp_checker: port-level checks on the header parser result channel
// depends on xnbhp_pkg; bound to xnb_header_parser

module xnbhp_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [xnbhp_pkg::TDATA_OUT_W-1:0]  m_tdata,
    input logic [xnbhp_pkg::TUSER_OUT_W-1:0]  m_tuser
);

    // a stalled result holds its contents
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a failed header never reports a shared count
    a_shared_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != xnbhp_pkg::ST_OK) |-> (m_tdata[129:99] == 31'd0))
        else $error("shared count set on an error result");

    // an uncompressed file reports equal sizes
    a_sizes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[3] |-> (m_tdata[67:36] == m_tdata[35:4]))
        else $error("size mismatch on uncompressed file");

    // target and padding stay in range
    a_target: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] != 2'd3) && (m_tdata[135:130] == 6'd0))
        else $error("bad target code or padding");

endmodule

bind xnb_header_parser xnbhp_checker u_xnbhp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: test/xnb_header_parser_tb.sv
`timescale 1ns / 1ps
// xnb_header_parser_tb: self-checking bench for the content-file header parser
// depends on xnbhp_pkg and xnb_header_parser; streams directed and random files and
// compares every result against a local header tracker

module xnb_header_parser_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 10;

    // progress of one varint byte
    typedef enum {VI_MORE, VI_DONE, VI_OVERLONG} varint_step_t;

    // one stream transaction as queued for sending
    typedef struct {
        xnbhp_pkg::kind_t kind;
        logic [7:0]       value;
    } stream_item_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [xnbhp_pkg::TDATA_IN_W-1:0] s_tdata = '0;
    logic [xnbhp_pkg::TUSER_IN_W-1:0] s_tuser = '0;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [xnbhp_pkg::TDATA_OUT_W-1:0] m_tdata;
    logic [xnbhp_pkg::TUSER_OUT_W-1:0] m_tuser;

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;
    int items_sent = 0;
    int headers_predicted = 0;

    xnbhp_pkg::result_t expected_headers[$];
    stream_item_t file_stream[$];

    // header tracker state
    xnbhp_pkg::phase_t hdr_phase;
    logic [2:0]  hdr_pos;
    logic [31:0] hdr_varint;
    logic [31:0] hdr_word;
    logic [30:0] hdr_readers_left;
    logic [30:0] hdr_skip_left;
    logic [1:0]  hdr_target;
    logic [1:0]  hdr_flags;
    logic [31:0] hdr_csize;
    logic [31:0] hdr_usize;
    logic [30:0] hdr_readers;

    xnb_header_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("xnb_header_parser_tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // header tracker
    // ------------------------------------------------------------------

    function automatic void header_clear();
        hdr_phase = xnbhp_pkg::PH_MAGIC0;
        hdr_pos = '0;
        hdr_varint = '0;
        hdr_word = '0;
        hdr_readers_left = '0;
        hdr_skip_left = '0;
        hdr_target = '0;
        hdr_flags = '0;
        hdr_csize = '0;
        hdr_usize = '0;
        hdr_readers = '0;
    endfunction

    // queue the one result of this file and stop parsing
    function automatic void header_emit(xnbhp_pkg::status_t st, logic [30:0] shared);
        xnbhp_pkg::result_t r;
        r.status = st;
        r.target = hdr_target;
        r.high_def = hdr_flags[0];
        r.compressed = hdr_flags[1];
        r.csize = hdr_csize;
        r.usize = hdr_usize;
        r.reader_count = hdr_readers;
        r.shared_count = shared;
        expected_headers.push_back(r);
        headers_predicted++;
        hdr_phase = xnbhp_pkg::PH_DONE;
    endfunction

    // 7-bit little-endian varint, at most five bytes
    function automatic varint_step_t varint_step(logic [7:0] b, output logic [31:0] val);
        int shift;
        logic [31:0] low7;
        shift = 7 * hdr_pos;
        low7 = {25'd0, b[6:0]};
        if (shift < 32)
            hdr_varint = hdr_varint | (low7 << shift);
        if (b[7]) begin
            if (hdr_pos >= xnbhp_pkg::VARINT_LAST)
                return VI_OVERLONG;
            hdr_pos = hdr_pos + 3'd1;
            return VI_MORE;
        end
        val = hdr_varint;
        hdr_varint = '0;
        hdr_pos = '0;
        return VI_DONE;
    endfunction

    // little-endian 32-bit word, true on the fourth byte
    function automatic bit word_step(logic [7:0] b, output logic [31:0] val);
        logic [1:0] idx;
        logic [31:0] wide;
        idx = hdr_pos[1:0];
        wide = {24'd0, b};
        hdr_word = hdr_word | (wide << (8 * idx));
        if (idx < xnbhp_pkg::WORD_LAST) begin
            hdr_pos = {1'b0, idx} + 3'd1;
            return 1'b0;
        end
        val = hdr_word;
        hdr_word = '0;
        hdr_pos = '0;
        return 1'b1;
    endfunction

    function automatic void predict_header(xnbhp_pkg::kind_t k, logic [7:0] b);
        logic [31:0] v;
        varint_step_t vs;
        if (k == xnbhp_pkg::KIND_RESTART) begin
            header_clear();
            return;
        end
        if (k == xnbhp_pkg::KIND_NONE || hdr_phase == xnbhp_pkg::PH_DONE)
            return;
        if (k == xnbhp_pkg::KIND_END) begin
            header_emit(xnbhp_pkg::ST_TRUNC, '0);
            return;
        end
        case (hdr_phase)
            xnbhp_pkg::PH_MAGIC0: begin
                if (b != xnbhp_pkg::CH_X) header_emit(xnbhp_pkg::ST_MAGIC, '0);
                else hdr_phase = xnbhp_pkg::PH_MAGIC1;
            end
            xnbhp_pkg::PH_MAGIC1: begin
                if (b != xnbhp_pkg::CH_N) header_emit(xnbhp_pkg::ST_MAGIC, '0);
                else hdr_phase = xnbhp_pkg::PH_MAGIC2;
            end
            xnbhp_pkg::PH_MAGIC2: begin
                if (b != xnbhp_pkg::CH_B) header_emit(xnbhp_pkg::ST_MAGIC, '0);
                else hdr_phase = xnbhp_pkg::PH_TARGET;
            end
            xnbhp_pkg::PH_TARGET: begin
                if (b == xnbhp_pkg::CH_W_LOWER) begin
                    hdr_target = xnbhp_pkg::TGT_WINDOWS;
                    hdr_phase = xnbhp_pkg::PH_VERSION;
                end else if (b == xnbhp_pkg::CH_M_LOWER) begin
                    hdr_target = xnbhp_pkg::TGT_PHONE;
                    hdr_phase = xnbhp_pkg::PH_VERSION;
                end else if (b == xnbhp_pkg::CH_X_LOWER) begin
                    hdr_target = xnbhp_pkg::TGT_CONSOLE;
                    hdr_phase = xnbhp_pkg::PH_VERSION;
                end else begin
                    header_emit(xnbhp_pkg::ST_TARGET, '0);
                end
            end
            xnbhp_pkg::PH_VERSION: begin
                if (b != xnbhp_pkg::FMT_VERSION) header_emit(xnbhp_pkg::ST_VERSION, '0);
                else hdr_phase = xnbhp_pkg::PH_FLAGS;
            end
            xnbhp_pkg::PH_FLAGS: begin
                hdr_flags = {b[7], b[0]};
                hdr_pos = '0;
                hdr_word = '0;
                hdr_phase = xnbhp_pkg::PH_CSIZE;
            end
            xnbhp_pkg::PH_CSIZE: begin
                if (word_step(b, v)) begin
                    hdr_csize = v;
                    if (hdr_flags[1]) begin
                        hdr_phase = xnbhp_pkg::PH_USIZE;
                    end else begin
                        hdr_usize = v;
                        hdr_phase = xnbhp_pkg::PH_RCOUNT;
                    end
                end
            end
            xnbhp_pkg::PH_USIZE: begin
                if (word_step(b, v)) begin
                    hdr_usize = v;
                    hdr_phase = xnbhp_pkg::PH_RCOUNT;
                end
            end
            xnbhp_pkg::PH_RCOUNT, xnbhp_pkg::PH_NAMELEN, xnbhp_pkg::PH_SHARED: begin
                vs = varint_step(b, v);
                if (vs == VI_OVERLONG) begin
                    header_emit(xnbhp_pkg::ST_OVERLONG, '0);
                end else if (vs == VI_DONE) begin
                    if (v[31]) begin
                        header_emit(xnbhp_pkg::ST_NEGATIVE, '0);
                    end else if (hdr_phase == xnbhp_pkg::PH_SHARED) begin
                        header_emit(xnbhp_pkg::ST_OK, v[30:0]);
                    end else if (hdr_phase == xnbhp_pkg::PH_RCOUNT) begin
                        hdr_readers = v[30:0];
                        hdr_readers_left = v[30:0];
                        hdr_phase = (v == 0) ? xnbhp_pkg::PH_SHARED : xnbhp_pkg::PH_NAMELEN;
                    end else begin
                        hdr_skip_left = v[30:0];
                        hdr_phase = (v == 0) ? xnbhp_pkg::PH_RVERSION :
                                               xnbhp_pkg::PH_NAMESKIP;
                    end
                end
            end
            xnbhp_pkg::PH_NAMESKIP: begin
                hdr_skip_left = hdr_skip_left - 31'd1;
                if (hdr_skip_left == 0)
                    hdr_phase = xnbhp_pkg::PH_RVERSION;
            end
            xnbhp_pkg::PH_RVERSION: begin
                if (word_step(b, v)) begin
                    hdr_readers_left = hdr_readers_left - 31'd1;
                    hdr_phase = (hdr_readers_left == 0) ? xnbhp_pkg::PH_SHARED :
                                                          xnbhp_pkg::PH_NAMELEN;
                end
            end
            default: hdr_phase = xnbhp_pkg::PH_DONE;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            error_count++;
        end
    endfunction

    // receiver: random stalls and one compare per result transaction
    always @(posedge aclk) begin
        xnbhp_pkg::result_t want;
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= stall_pct);
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_headers.size() == 0) begin
                $error("result with no header pending: status %0d", m_tuser);
                error_count++;
            end else begin
                want = expected_headers.pop_front();
                check_field("status", want.status, m_tuser);
                check_field("target_platform", want.target, m_tdata[1:0]);
                check_field("high_def", want.high_def, m_tdata[2]);
                check_field("is_compressed", want.compressed, m_tdata[3]);
                check_field("compressed_size", want.csize, m_tdata[35:4]);
                check_field("uncompressed_size", want.usize, m_tdata[67:36]);
                check_field("reader_count", want.reader_count, m_tdata[98:68]);
                check_field("shared_count", want.shared_count, m_tdata[129:99]);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    // one transaction, with random idle cycles ahead of it
    task automatic send_item(xnbhp_pkg::kind_t k, logic [7:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= k;
        s_tdata <= b;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        predict_header(k, b);
        items_sent++;
    endtask

    task automatic send_byte(logic [7:0] b);
        send_item(xnbhp_pkg::KIND_DATA, b);
    endtask

    // queued file, with stray unused-kind transactions mixed in
    task automatic play_stream();
        foreach (file_stream[i]) begin
            if ($urandom_range(0, 99) < 3)
                send_item(xnbhp_pkg::KIND_NONE, 8'($urandom));
            send_item(file_stream[i].kind, file_stream[i].value);
        end
    endtask

    task automatic wait_drained();
        while (expected_headers.size() != 0)
            @(posedge aclk);
    endtask

    function automatic void put_item(xnbhp_pkg::kind_t k, logic [7:0] b);
        stream_item_t it;
        it.kind = k;
        it.value = b;
        file_stream.push_back(it);
    endfunction

    function automatic void put_byte(logic [7:0] b);
        put_item(xnbhp_pkg::KIND_DATA, b);
    endfunction

    function automatic void put_word(logic [31:0] w);
        for (int i = 0; i < 4; i++)
            put_byte(w[8*i +: 8]);
    endfunction

    function automatic void put_varint(logic [31:0] v);
        logic [7:0] b;
        do begin
            b = {1'b0, v[6:0]};
            v = v >> 7;
            if (v != 0)
                b[7] = 1'b1;
            put_byte(b);
        end while (v != 0);
    endfunction

    // five bytes, all with the continuation bit
    function automatic void put_overlong();
        repeat (5) put_byte(8'($urandom) | 8'h80);
    endfunction

    // five-byte varint whose last byte carries junk above bit 31
    function automatic void put_wide_varint();
        repeat (4) put_byte(8'($urandom) | 8'h80);
        put_byte(8'($urandom) & 8'h7f);
    endfunction

    function automatic logic [31:0] rand_size();
        case ($urandom_range(0, 5))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    // a count whose varint length varies from one to five bytes
    function automatic logic [31:0] rand_count();
        return $urandom >> $urandom_range(1, 31);
    endfunction

    // one random file: mostly well-formed, some damaged or cut short
    function automatic void build_random_file();
        int n_readers;
        int sub;
        int cut;
        int len;
        logic [7:0] flags;
        bit broken;
        file_stream.delete();
        put_item(xnbhp_pkg::KIND_RESTART, 8'($urandom));
        put_byte(xnbhp_pkg::CH_X);
        put_byte(xnbhp_pkg::CH_N);
        put_byte(xnbhp_pkg::CH_B);
        case ($urandom_range(0, 2))
            0: put_byte(xnbhp_pkg::CH_W_LOWER);
            1: put_byte(xnbhp_pkg::CH_M_LOWER);
            default: put_byte(xnbhp_pkg::CH_X_LOWER);
        endcase
        put_byte(xnbhp_pkg::FMT_VERSION);
        flags = 8'($urandom);
        put_byte(flags);
        put_word(rand_size());
        if (flags[7])
            put_word(rand_size());
        broken = 1'b0;

        // reader table
        sub = $urandom_range(0, 99);
        if (sub < 6) begin
            put_varint(32'h8000_0000 | $urandom);
            broken = 1'b1;
        end else if (sub < 11) begin
            put_overlong();
            broken = 1'b1;
        end else if (sub < 19) begin
            // random reader count, cut off by an end of stream
            put_varint(rand_count());
            repeat ($urandom_range(0, 6)) put_byte(8'($urandom));
            put_item(xnbhp_pkg::KIND_END, 8'($urandom));
            broken = 1'b1;
        end else begin
            n_readers = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
            put_varint(n_readers);
            for (int i = 0; i < n_readers && !broken; i++) begin
                sub = $urandom_range(0, 99);
                if (sub < 4) begin
                    put_varint(32'h8000_0000 | $urandom);
                    broken = 1'b1;
                end else if (sub < 7) begin
                    put_overlong();
                    broken = 1'b1;
                end else begin
                    len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    put_varint(len);
                    repeat (len) put_byte(8'($urandom));
                    put_word($urandom);
                end
            end
        end

        // shared resource count
        if (!broken) begin
            sub = $urandom_range(0, 99);
            if (sub < 6)
                put_varint(32'h8000_0000 | $urandom);
            else if (sub < 11)
                put_overlong();
            else if (sub < 16)
                put_wide_varint();
            else
                put_varint(rand_count());
        end

        // damage to the fixed header or an early end of stream
        sub = $urandom_range(0, 99);
        if (sub < 10) begin
            file_stream[$urandom_range(1, 5)].value = 8'($urandom);
        end else if (sub < 22) begin
            cut = $urandom_range(1, file_stream.size() - 1);
            while (file_stream.size() > cut)
                void'(file_stream.pop_back());
            put_item(xnbhp_pkg::KIND_END, 8'($urandom));
        end

        // trailing traffic after the result, ignored by the parser
        sub = $urandom_range(0, 99);
        if (sub < 35)
            put_item(xnbhp_pkg::KIND_END, 8'($urandom));
        else if (sub < 70)
            repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // bad first magic byte, then late end, ignored bytes and an unused kind
    task automatic test_bad_magic_and_kinds();
        send_byte(8'h00);
        send_item(xnbhp_pkg::KIND_END, 8'h00);
        send_byte(8'hff);
        send_item(xnbhp_pkg::KIND_NONE, 8'hff);
    endtask

    task automatic test_bad_target();
        send_item(xnbhp_pkg::KIND_RESTART, 8'h00);
        send_byte(xnbhp_pkg::CH_X);
        send_byte(xnbhp_pkg::CH_N);
        send_byte(xnbhp_pkg::CH_B);
        send_byte(8'h7a);  // 'z'
    endtask

    // compressed high-def console file, extreme sizes, empty reader list
    task automatic test_full_header();
        send_item(xnbhp_pkg::KIND_RESTART, 8'hff);
        send_byte(xnbhp_pkg::CH_X);
        send_byte(xnbhp_pkg::CH_N);
        send_byte(xnbhp_pkg::CH_B);
        send_byte(xnbhp_pkg::CH_X_LOWER);
        send_byte(xnbhp_pkg::FMT_VERSION);
        send_byte(8'h81);
        repeat (4) send_byte(8'hff);
        repeat (4) send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h7f);
    endtask

    task automatic test_random_files(int unsigned idle, int unsigned stall,
                                     int item_goal, int header_goal);
        int first_item;
        int first_header;
        send_idle_pct = idle;
        stall_pct = stall;
        first_item = items_sent;
        first_header = headers_predicted;
        while (items_sent - first_item < item_goal ||
               headers_predicted - first_header < header_goal) begin
            build_random_file();
            play_stream();
        end
    endtask

    // sender holds off until every pending result has come out
    task automatic test_pause_for_results();
        send_idle_pct = 20;
        stall_pct = 50;
        build_random_file();
        play_stream();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        wait_drained();
        build_random_file();
        play_stream();
    endtask

    initial begin
        header_clear();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_bad_magic_and_kinds();
        test_bad_target();
        test_full_header();
        test_random_files(0, 0, 200, 10);
        test_pause_for_results();
        test_random_files(85, 0, 200, 10);
        test_random_files(0, 85, 200, 10);
        test_random_files(20, 20, 200, 10);

        s_tvalid <= 1'b0;
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("xnb_header_parser_tb: done, clean");
        else
            $display("xnb_header_parser_tb: done, errors");
        $finish;
    end

endmodule
